FILE: design/spm_pkg.sv
// Shared constants, types and helpers of the spiral matrix readout block.
package spm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int DIM_W     = 4;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = 7;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CQ_DEPTH  = 2;
	localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH  = 4;
	localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 2);

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RIGHT,
		BK_DOWN,
		BK_LEFT,
		BK_UP
	} back_state_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: design/spm_front.sv
// Front end: configuration registers, element load and readout request.
module spm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [spm_pkg::DATA_W-1:0] elem_value,
	input  logic                              cfg_we,
	input  logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spm_pkg::DIM_W-1:0]         cfg_data,
	input  spm_pkg::q_stat_t                  cq_stat,
	input  logic                              back_busy,
	output spm_pkg::mem_wr_t                  mem_wr,
	output logic                              cq_push,
	output spm_pkg::cmd_t                     cq_cmd
);

	logic [spm_pkg::DIM_W-1:0]   row_count_q;
	logic [spm_pkg::DIM_W-1:0]   col_count_q;
	logic [spm_pkg::CNT_W-1:0]   load_count_q;
	logic [spm_pkg::DIM_W-1:0]   rows;
	logic [spm_pkg::DIM_W-1:0]   cols;
	logic [2*spm_pkg::DIM_W-1:0] prod;
	logic [spm_pkg::CNT_W-1:0]   total;
	logic [spm_pkg::CNT_W-1:0]   cnt_nxt;
	logic                        accept;
	logic                        done;

	assign rows    = spm_pkg::eff_dim(row_count_q);
	assign cols    = spm_pkg::eff_dim(col_count_q);
	assign prod    = rows * cols;
	assign total   = prod[spm_pkg::CNT_W-1:0];
	assign full    = cq_stat.full | ~cq_stat.empty | back_busy;
	assign accept  = push & ~full;
	assign cnt_nxt = load_count_q + spm_pkg::CNT_W'(1);
	assign done    = cnt_nxt >= total;

	assign mem_wr.en   = accept;
	assign mem_wr.addr = load_count_q[spm_pkg::ADDR_W-1:0];
	assign mem_wr.data = elem_value;

	assign cq_push     = accept & done;
	assign cq_cmd.rows = rows;
	assign cq_cmd.cols = cols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= spm_pkg::DIM_W'(1);
			col_count_q <= spm_pkg::DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				spm_pkg::REG_ROW_COUNT: row_count_q <= cfg_data;
				spm_pkg::REG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (accept) begin
			load_count_q <= done ? '0 : cnt_nxt;
		end
	end

endmodule

FILE: design/spm_cmd_queue.sv
// Short queue of readout requests between the front and back ends.
module spm_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  spm_pkg::cmd_t    wr_cmd,
	input  logic             rd_en,
	output spm_pkg::cmd_t    rd_cmd,
	output spm_pkg::q_stat_t stat
);

	spm_pkg::cmd_t                slot_q [spm_pkg::CQ_DEPTH];
	logic [spm_pkg::CQ_PTR_W-1:0] wr_ptr_q;
	logic [spm_pkg::CQ_PTR_W-1:0] rd_ptr_q;
	logic [spm_pkg::CQ_CNT_W-1:0] cnt_q;
	logic                         do_wr;
	logic                         do_rd;

	assign stat.empty = cnt_q == '0;
	assign stat.full  = cnt_q == spm_pkg::CQ_CNT_W'(spm_pkg::CQ_DEPTH);
	assign do_wr      = wr_en & ~stat.full;
	assign do_rd      = rd_en & ~stat.empty;
	assign rd_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + spm_pkg::CQ_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + spm_pkg::CQ_PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + spm_pkg::CQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - spm_pkg::CQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/spm_back.sv
// Back end: matrix store, spiral address sequencer and result queue.
module spm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spm_pkg::mem_wr_t                  mem_wr,
	input  spm_pkg::q_stat_t                  cq_stat,
	input  spm_pkg::cmd_t                     cq_cmd,
	output logic                              cq_pop,
	output logic                              busy,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [spm_pkg::DATA_W-1:0] out_value,
	output logic                              is_last
);

	typedef struct packed {
		logic [spm_pkg::DATA_W-1:0] value;
		logic                       last;
	} oq_entry_t;

	logic [spm_pkg::DATA_W-1:0] mem_q [spm_pkg::DEPTH];

	spm_pkg::back_state_t state_q, state_d;
	logic [spm_pkg::IDX_W-1:0] r_q, r_d, c_q, c_d;
	logic [spm_pkg::IDX_W-1:0] top_q, top_d, bot_q, bot_d;
	logic [spm_pkg::IDX_W-1:0] left_q, left_d, right_q, right_d;
	logic [spm_pkg::DIM_W-1:0] cols_q, cols_d;
	logic [spm_pkg::CNT_W-1:0] remain_q, remain_d;

	logic [spm_pkg::IDX_W+spm_pkg::DIM_W-1:0] rprod;
	logic [2*spm_pkg::DIM_W-1:0]              tprod;
	logic [spm_pkg::ADDR_W-1:0]               rd_addr;
	logic                                     issue;
	logic                                     last_beat;

	logic                       rd_v_s1;
	logic                       rd_last_s1;
	logic [spm_pkg::DATA_W-1:0] data_s1;

	oq_entry_t                    oq_q [spm_pkg::OQ_DEPTH];
	logic [spm_pkg::OQ_PTR_W-1:0] oq_wr_q;
	logic [spm_pkg::OQ_PTR_W-1:0] oq_rd_q;
	logic [spm_pkg::OQ_CNT_W-1:0] oq_cnt_q;
	logic [spm_pkg::OQ_CNT_W-1:0] oq_load;
	logic                         oq_pop;

	assign rprod   = r_q * cols_q;
	assign tprod   = cq_cmd.rows * cq_cmd.cols;
	assign rd_addr = rprod[spm_pkg::ADDR_W-1:0]
		+ {{(spm_pkg::ADDR_W-spm_pkg::IDX_W){1'b0}}, c_q};
	assign oq_load   = oq_cnt_q + spm_pkg::OQ_CNT_W'(rd_v_s1);
	assign issue     = (state_q != spm_pkg::BK_IDLE)
		&& (oq_load < spm_pkg::OQ_CNT_W'(spm_pkg::OQ_DEPTH));
	assign last_beat = remain_q == spm_pkg::CNT_W'(1);
	assign busy      = state_q != spm_pkg::BK_IDLE;
	assign cq_pop    = (state_q == spm_pkg::BK_IDLE) & ~cq_stat.empty;

	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		c_d      = c_q;
		top_d    = top_q;
		bot_d    = bot_q;
		left_d   = left_q;
		right_d  = right_q;
		cols_d   = cols_q;
		remain_d = remain_q;
		case (state_q)
			spm_pkg::BK_IDLE: begin
				if (cq_pop) begin
					state_d  = spm_pkg::BK_RIGHT;
					r_d      = '0;
					c_d      = '0;
					top_d    = '0;
					left_d   = '0;
					bot_d    = spm_pkg::IDX_W'(cq_cmd.rows - spm_pkg::DIM_W'(1));
					right_d  = spm_pkg::IDX_W'(cq_cmd.cols - spm_pkg::DIM_W'(1));
					cols_d   = cq_cmd.cols;
					remain_d = tprod[spm_pkg::CNT_W-1:0];
				end
			end
			spm_pkg::BK_RIGHT: begin
				if (issue) begin
					if (c_q < right_q) begin
						c_d = c_q + spm_pkg::IDX_W'(1);
					end else begin
						top_d   = top_q + spm_pkg::IDX_W'(1);
						r_d     = r_q + spm_pkg::IDX_W'(1);
						state_d = spm_pkg::BK_DOWN;
					end
				end
			end
			spm_pkg::BK_DOWN: begin
				if (issue) begin
					if (r_q < bot_q) begin
						r_d = r_q + spm_pkg::IDX_W'(1);
					end else begin
						right_d = right_q - spm_pkg::IDX_W'(1);
						c_d     = c_q - spm_pkg::IDX_W'(1);
						state_d = spm_pkg::BK_LEFT;
					end
				end
			end
			spm_pkg::BK_LEFT: begin
				if (issue) begin
					if (c_q > left_q) begin
						c_d = c_q - spm_pkg::IDX_W'(1);
					end else begin
						bot_d   = bot_q - spm_pkg::IDX_W'(1);
						r_d     = r_q - spm_pkg::IDX_W'(1);
						state_d = spm_pkg::BK_UP;
					end
				end
			end
			spm_pkg::BK_UP: begin
				if (issue) begin
					if (r_q > top_q) begin
						r_d = r_q - spm_pkg::IDX_W'(1);
					end else begin
						left_d  = left_q + spm_pkg::IDX_W'(1);
						c_d     = c_q + spm_pkg::IDX_W'(1);
						state_d = spm_pkg::BK_RIGHT;
					end
				end
			end
			default: state_d = spm_pkg::BK_IDLE;
		endcase
		if (issue) begin
			remain_d = remain_q - spm_pkg::CNT_W'(1);
			if (last_beat) begin
				state_d = spm_pkg::BK_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		r_q      <= r_d;
		c_q      <= c_d;
		top_q    <= top_d;
		bot_q    <= bot_d;
		left_q   <= left_d;
		right_q  <= right_d;
		cols_q   <= cols_d;
		remain_q <= remain_d;
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem_q[mem_wr.addr] <= mem_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1    <= mem_q[rd_addr];
			rd_last_s1 <= last_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	// result queue
	assign empty     = oq_cnt_q == '0;
	assign oq_pop    = pop & ~empty;
	assign out_value = oq_q[oq_rd_q].value;
	assign is_last   = oq_q[oq_rd_q].last;

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			oq_q[oq_wr_q] <= '{value: data_s1, last: rd_last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (rd_v_s1) begin
				oq_wr_q <= oq_wr_q + spm_pkg::OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + spm_pkg::OQ_PTR_W'(1);
			end
			case ({rd_v_s1, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + spm_pkg::OQ_CNT_W'(1);
				2'b01:   oq_cnt_q <= oq_cnt_q - spm_pkg::OQ_CNT_W'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule

FILE: design/spiral_matrix_readout.sv
// Top level of the spiral matrix readout block.
//
//  channel   direction  handshake          beat payload
//  element   in         push / full        elem_value
//  result    out        pop / empty        out_value, is_last
//  config    in         cfg_we             cfg_index, cfg_data
//
//  Elements load while full is low; full stays low while a matrix loads.
//  The last element queues a readout: full rises until the sequencer has read
//  all rows*cols entries, one store read per cycle while the result queue has
//  room; the first result passes the data_s1 register and the result queue.
//  A stalled result queue holds the sequencer; reset needs no clearing pass.
module spiral_matrix_readout (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [spm_pkg::DATA_W-1:0] elem_value,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [spm_pkg::DATA_W-1:0] out_value,
	output logic                              is_last,
	input  logic                              cfg_we,
	input  logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spm_pkg::DIM_W-1:0]         cfg_data
);

	spm_pkg::q_stat_t cq_stat;
	spm_pkg::cmd_t    cq_wr_cmd;
	spm_pkg::cmd_t    cq_rd_cmd;
	spm_pkg::mem_wr_t mem_wr;
	logic             cq_push;
	logic             cq_pop;
	logic             back_busy;

	spm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.elem_value (elem_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cq_stat    (cq_stat),
		.back_busy  (back_busy),
		.mem_wr     (mem_wr),
		.cq_push    (cq_push),
		.cq_cmd     (cq_wr_cmd)
	);

	spm_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cq_push),
		.wr_cmd (cq_wr_cmd),
		.rd_en  (cq_pop),
		.rd_cmd (cq_rd_cmd),
		.stat   (cq_stat)
	);

	spm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.cq_stat   (cq_stat),
		.cq_cmd    (cq_rd_cmd),
		.cq_pop    (cq_pop),
		.busy      (back_busy),
		.empty     (empty),
		.pop       (pop),
		.out_value (out_value),
		.is_last   (is_last)
	);

endmodule

FILE: design/spm_checker.sv
// Port-level checks of the spiral matrix readout block and their binding.
module spm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              push,
	input logic                              full,
	input logic                              empty,
	input logic                              pop,
	input logic signed [spm_pkg::DATA_W-1:0] out_value,
	input logic                              is_last
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_value) && $stable(is_last))
		else $error("stalled result beat changed");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without an element beat");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("block not idle in reset");

endmodule

bind spiral_matrix_readout spm_checker u_spm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_value (out_value),
	.is_last   (is_last)
);

FILE: verif/spm_spiral_check.sv
// Watches the element, config and result channels, predicts the spiral order and checks each beat.
module spm_spiral_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic signed [spm_pkg::DATA_W-1:0] elem_value,
	input  logic                              empty,
	input  logic                              pop,
	input  logic signed [spm_pkg::DATA_W-1:0] out_value,
	input  logic                              is_last,
	input  logic                              cfg_we,
	input  logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spm_pkg::DIM_W-1:0]         cfg_data,
	output int                                errors,
	output int                                pending,
	output int                                checked
);

	localparam int MAX_REPORTS = 30;

	typedef struct {
		logic signed [spm_pkg::DATA_W-1:0] value;
		logic                              last;
	} spiral_beat_t;

	logic [spm_pkg::DATA_W-1:0] elem_store [spm_pkg::DEPTH];
	logic [spm_pkg::DIM_W-1:0]  row_reg = spm_pkg::DIM_W'(1);
	logic [spm_pkg::DIM_W-1:0]  col_reg = spm_pkg::DIM_W'(1);
	logic [spm_pkg::CNT_W-1:0]  load_cnt = '0;
	spiral_beat_t               spiral_q [$];
	spiral_beat_t               want;

	function automatic int clamp_dim(logic [spm_pkg::DIM_W-1:0] v);
		if (v == '0) return 1;
		if (v > spm_pkg::MAX_DIM) return spm_pkg::MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [spm_pkg::DATA_W-1:0] store_at(int r, int c, int cols);
		return elem_store[spm_pkg::ADDR_W'(r * cols + c)];
	endfunction

	task automatic take_element(logic [spm_pkg::DATA_W-1:0] v);
		int rows, cols, t, b, l, rt, i;
		logic [spm_pkg::DATA_W-1:0] order [$];
		spiral_beat_t beat;
		rows = clamp_dim(row_reg);
		cols = clamp_dim(col_reg);
		elem_store[load_cnt[spm_pkg::ADDR_W-1:0]] = v;
		load_cnt = load_cnt + 1'b1;
		if (int'(load_cnt) < rows * cols) return;
		load_cnt = '0;
		t = 0;
		b = rows - 1;
		l = 0;
		rt = cols - 1;
		while (t <= b && l <= rt) begin
			for (i = l; i <= rt; i++) order.push_back(store_at(t, i, cols));
			t++;
			for (i = t; i <= b; i++) order.push_back(store_at(i, rt, cols));
			rt--;
			if (t <= b) begin
				for (i = rt; i >= l; i--) order.push_back(store_at(b, i, cols));
				b--;
			end
			if (l <= rt) begin
				for (i = b; i >= t; i--) order.push_back(store_at(i, l, cols));
				l++;
			end
		end
		foreach (order[k]) begin
			beat.value = order[k];
			beat.last = (k == order.size() - 1);
			spiral_q.push_back(beat);
		end
	endtask

	task automatic flag(string msg);
		if (errors < MAX_REPORTS) $error("%s", msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_reg = spm_pkg::DIM_W'(1);
			col_reg = spm_pkg::DIM_W'(1);
			load_cnt = '0;
			spiral_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spm_pkg::REG_ROW_COUNT: row_reg = cfg_data;
					spm_pkg::REG_COL_COUNT: col_reg = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (spiral_q.size() == 0) begin
					flag($sformatf("out_value: expected no beat, actual %0d", out_value));
				end else begin
					want = spiral_q.pop_front();
					checked++;
					if (out_value !== want.value)
						flag($sformatf("out_value: expected %0d, actual %0d",
							want.value, out_value));
					if (is_last !== want.last)
						flag($sformatf("is_last: expected %0b, actual %0b",
							want.last, is_last));
				end
			end
			if (push && !full) take_element(elem_value);
		end
		pending = spiral_q.size();
	end

endmodule

FILE: verif/tb.sv
// Testbench top: drives element and config beats, pops results and gives the verdict.
module tb;

	localparam int LIMIT      = 200000;
	localparam int DRAIN      = 12;
	localparam int LONG_HOLD  = 300;
	localparam int RAND_ITEMS = 210;
	localparam logic [spm_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = spm_pkg::CFG_IDX_W'(2);
	localparam logic [spm_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = spm_pkg::CFG_IDX_W'(3);

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              push = 1'b0;
	logic                              full;
	logic signed [spm_pkg::DATA_W-1:0] elem_value = '0;
	logic                              empty;
	logic                              pop = 1'b0;
	logic signed [spm_pkg::DATA_W-1:0] out_value;
	logic                              is_last;
	logic                              cfg_we = 1'b0;
	logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [spm_pkg::DIM_W-1:0]         cfg_data = '0;

	int errors, pending, checked;
	int cycles = 0;
	int sent = 0;
	bit send_steady = 1'b0;
	bit long_hold_req = 1'b0;

	spiral_matrix_readout dut (.*);

	spm_spiral_check chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [spm_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return spm_pkg::MAX_DIM;
		if (r < 3) return $urandom_range(5, spm_pkg::MAX_DIM - 1);
		return $urandom_range(1, 4);
	endfunction

	// out-of-range encodings that clamp to the same size
	function automatic logic [spm_pkg::DIM_W-1:0] enc_dim(int d);
		if (d == 1 && $urandom_range(0, 2) == 0) return '0;
		if (d == spm_pkg::MAX_DIM && $urandom_range(0, 2) == 0)
			return spm_pkg::DIM_W'($urandom_range(spm_pkg::MAX_DIM + 1,
				(1 << spm_pkg::DIM_W) - 1));
		return spm_pkg::DIM_W'(d);
	endfunction

	// Pop side: random stalls, steady stretches, one long hold on request.
	initial begin
		int hold, ticks;
		bit steady;
		hold = 0;
		ticks = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			ticks++;
			if (ticks % 64 == 0) steady = ($urandom_range(0, 3) == 0);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				pop <= 1'b1;
			end else begin
				pop <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	task automatic send_elem(logic [spm_pkg::DATA_W-1:0] v);
		int gap;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		elem_value <= v;
		do @(posedge clk); while (full);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_matrix(int n);
		repeat (n) send_elem(pick_value());
	endtask

	task automatic set_reg(logic [spm_pkg::CFG_IDX_W-1:0] idx,
		logic [spm_pkg::DIM_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_dims(int rows, int cols);
		set_reg(spm_pkg::REG_ROW_COUNT, enc_dim(rows));
		set_reg(spm_pkg::REG_COL_COUNT, enc_dim(cols));
	endtask

	// hold input until every expected beat is out and the block is quiet
	task automatic settle();
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// finish a partly loaded matrix under new dimensions
	task automatic resize_and_finish(int rows, int cols);
		settle();
		set_dims(rows, cols);
		do send_elem(pick_value()); while (pending == 0);
	endtask

	initial begin
		int rows, cols, total, mats;
		bit first;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// 1x1 after reset, field extremes
		send_elem(32'h7FFF_FFFF);
		send_elem(32'h8000_0000);
		send_elem(32'hFFFF_FFFF);
		send_elem(32'h0000_0000);
		send_elem(32'h5555_5555);
		send_elem(32'hAAAA_AAAA);
		settle();
		set_reg(spm_pkg::REG_ROW_COUNT, '0);
		set_reg(spm_pkg::REG_COL_COUNT, '0);
		set_reg(REG_SPARE_2, '1);
		set_reg(REG_SPARE_3, spm_pkg::DIM_W'(7));
		send_elem(pick_value());
		settle();
		set_reg(spm_pkg::REG_ROW_COUNT, '1);
		set_reg(spm_pkg::REG_COL_COUNT, spm_pkg::DIM_W'(1));
		send_matrix(spm_pkg::MAX_DIM);
		// grow while loading
		settle();
		set_reg(spm_pkg::REG_ROW_COUNT, spm_pkg::DIM_W'(1));
		set_reg(spm_pkg::REG_COL_COUNT, spm_pkg::DIM_W'(2));
		send_elem(pick_value());
		settle();
		set_reg(spm_pkg::REG_ROW_COUNT, spm_pkg::DIM_W'(2));
		set_reg(spm_pkg::REG_COL_COUNT, spm_pkg::DIM_W'(2));
		send_matrix(3);
		// shrink below the loaded count
		settle();
		set_reg(spm_pkg::REG_ROW_COUNT, spm_pkg::DIM_W'(2));
		set_reg(spm_pkg::REG_COL_COUNT, spm_pkg::DIM_W'(3));
		send_matrix(3);
		settle();
		set_reg(spm_pkg::REG_ROW_COUNT, spm_pkg::DIM_W'(1));
		set_reg(spm_pkg::REG_COL_COUNT, spm_pkg::DIM_W'(2));
		send_elem(pick_value());

		first = 1'b1;
		while (sent < RAND_ITEMS) begin
			settle();
			send_steady = ($urandom_range(0, 3) == 0);
			rows = first ? spm_pkg::MAX_DIM : pick_dim();
			cols = first ? spm_pkg::MAX_DIM : pick_dim();
			total = rows * cols;
			set_dims(rows, cols);
			if ($urandom_range(0, 7) == 0)
				set_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					spm_pkg::DIM_W'($urandom));
			if (first) begin
				// full matrix against a stalled receiver, then one more beat held off by full
				send_matrix(total);
				long_hold_req = 1'b1;
				send_elem(pick_value());
				resize_and_finish(pick_dim(), pick_dim());
				first = 1'b0;
			end else begin
				mats = (total > 16) ? 1 : $urandom_range(1, 3);
				repeat (mats) send_matrix(total);
				if (total > 1 && $urandom_range(0, 4) == 0) begin
					send_matrix($urandom_range(1, total - 1));
					resize_and_finish(pick_dim(), pick_dim());
				end
			end
		end

		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		$display("%0d element beats sent, %0d spiral beats checked", sent, checked);
		$display("shapes 1x1 to 8x8, clamped sizes, ignored writes, resize mid-load, long stall");
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
